// ===== rtl/bbce_pkg.sv =====
// ----------------------------------------------------------------------------
// bbce_pkg
// Types and constants shared by the bank bit change event block.
// ----------------------------------------------------------------------------
`default_nettype none

package bbce_pkg;

  localparam int NUM_BANKS = 24;
  localparam int BITS_PER_BANK = 8;
  localparam int BIT_W = $clog2(BITS_PER_BANK);
  localparam int BANK_W = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
  localparam int POINT_W = 8;

  typedef struct packed {
    logic [7:0] bank;
    logic [7:0] data;
  } in_item_t;

  typedef struct packed {
    logic [POINT_W-1:0] point_id;
    logic               point_state;
    logic               last;
  } out_item_t;

  // Start request from the input side to the bit scanner
  typedef struct packed {
    logic                     valid;
    logic [BANK_W-1:0]        bank;
    logic [BITS_PER_BANK-1:0] data;
    logic [BITS_PER_BANK-1:0] diff;
  } scan_start_t;

  // One event from the bit scanner
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } scan_emit_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } scan_state_e;

endpackage : bbce_pkg

`default_nettype wire

// ===== rtl/bbce_store.sv =====
// ----------------------------------------------------------------------------
// bbce_store
// Last byte seen per bank, one write and one read port, cleared by reset.
// ----------------------------------------------------------------------------
`default_nettype none

module bbce_store
  import bbce_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     we_i,
  input  logic [BANK_W-1:0]        addr_i,
  input  logic [BITS_PER_BANK-1:0] wdata_i,
  output logic [BITS_PER_BANK-1:0] rdata_o
);

  logic [BITS_PER_BANK-1:0] store_q [NUM_BANKS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BANKS; i++) begin
        store_q[i] <= '0;
      end
    end else if (we_i) begin
      store_q[addr_i] <= wdata_i;
    end
  end

  // addr_i is range checked by the caller before use
  assign rdata_o = store_q[addr_i];

endmodule : bbce_store

`default_nettype wire

// ===== rtl/bbce_scan.sv =====
// ----------------------------------------------------------------------------
// bbce_scan
// Bit scanner: walks the changed-bit mask one bit per cycle and emits one
// event per set bit, holding while the output slot is full.
// ----------------------------------------------------------------------------
`default_nettype none

module bbce_scan
  import bbce_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  scan_start_t start_i,
  input  logic        slot_free_i,
  output scan_emit_t  emit_o,
  output logic        idle_o
);

  scan_state_e              state_q, state_d;
  logic [BIT_W-1:0]         bit_q, bit_d;
  logic [BITS_PER_BANK-1:0] diff_q, diff_d;
  logic [BITS_PER_BANK-1:0] data_q, data_d;
  logic [BANK_W-1:0]        bank_q, bank_d;

  logic                     hit;
  logic [BITS_PER_BANK-1:0] rem;
  logic [BANK_W+BIT_W-1:0]  point_idx;

  assign hit       = diff_q[bit_q];
  assign rem       = diff_q & ~(BITS_PER_BANK'(1) << bit_q);
  assign point_idx = {bank_q, bit_q};

  always_comb begin
    state_d = state_q;
    bit_d   = bit_q;
    diff_d  = diff_q;
    data_d  = data_q;
    bank_d  = bank_q;
    emit_o  = '0;
    emit_o.item.point_id    = POINT_W'(point_idx) + POINT_W'(1);
    emit_o.item.point_state = data_q[bit_q];
    emit_o.item.last        = (rem == '0);
    unique case (state_q)
      ST_IDLE: begin
        if (start_i.valid) begin
          diff_d  = start_i.diff;
          data_d  = start_i.data;
          bank_d  = start_i.bank;
          bit_d   = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // a clear bit never waits; a set bit waits for the output slot
        if (!hit || slot_free_i) begin
          bit_d = bit_q + BIT_W'(1);
          if (hit) begin
            emit_o.valid = 1'b1;
            diff_d       = rem;
            if (rem == '0) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      bit_q   <= '0;
      diff_q  <= '0;
    end else begin
      state_q <= state_d;
      bit_q   <= bit_d;
      diff_q  <= diff_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    bank_q <= bank_d;
  end

  assign idle_o = (state_q == ST_IDLE);

endmodule : bbce_scan

`default_nettype wire

// ===== rtl/bank_bit_change_events_unit.sv =====
// ----------------------------------------------------------------------------
// bank_bit_change_events_unit
// Per-bank change detector that turns each new bank byte into point events.
// ----------------------------------------------------------------------------
// A request carries a bank number and its new byte. Banks at or beyond
// NUM_BANKS are dropped in the cycle they are taken and the block stays
// ready. For a valid bank the byte is compared with the stored one and
// written back in the accept cycle; an unchanged byte also leaves the block ready.
// A changed byte hands the difference mask to the bit scanner, which looks
// at one bit per cycle from bit 0 up while the output side does not hold
// it, and stops after the highest changed bit; no new request is taken
// until the scanner is idle again. Events sit in an
// output register; while one waits the scanner moves on over unchanged bits
// and holds at the next changed bit until the register frees. The store
// is flip-flops cleared directly by reset; no clearing pass is needed.
`default_nettype none

module bank_bit_change_events_unit
  import bbce_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic                     accept;
  logic                     in_range;
  logic [BANK_W-1:0]        bank_idx;
  logic [BITS_PER_BANK-1:0] old_byte;
  logic                     scan_idle;
  logic                     slot_free;
  scan_start_t              start;
  scan_emit_t               emit;

  logic      out_valid_q, out_valid_d;
  out_item_t out_q;

  assign in_ready_o = scan_idle;
  assign accept     = in_valid_i && in_ready_o;
  assign in_range   = ({1'b0, in_item_i.bank} < 9'(NUM_BANKS));
  assign bank_idx   = in_item_i.bank[BANK_W-1:0];

  bbce_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (accept && in_range),
    .addr_i  (bank_idx),
    .wdata_i (in_item_i.data),
    .rdata_o (old_byte)
  );

  always_comb begin
    start.bank  = bank_idx;
    start.data  = in_item_i.data;
    start.diff  = old_byte ^ in_item_i.data;
    start.valid = accept && in_range && (start.diff != '0);
  end

  assign slot_free = !out_valid_q || out_ready_i;

  bbce_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .slot_free_i (slot_free),
    .emit_o      (emit),
    .idle_o      (scan_idle)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit.valid) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.valid) begin
      out_q <= emit.item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule : bank_bit_change_events_unit

`default_nettype wire

// ===== rtl/bbce_checker.sv =====
// ----------------------------------------------------------------------------
// bbce_checker
// Port-level checks for the bank bit change event block.
// ----------------------------------------------------------------------------
`default_nettype none

module bbce_checker
  import bbce_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_item_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  // stalled event holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled event changed");

  // dropped bank leaves the block ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && ({1'b0, in_item_i.bank} >= 9'(NUM_BANKS))
    |=> in_ready_o)
    else $error("out of range bank started a scan");

  // a run is still in progress until its last event shows
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.last |-> !in_ready_o)
    else $error("ready before the last event of a run");

  // point numbers stay inside the configured banks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, out_item_o.point_id} <= 9'(NUM_BANKS * BITS_PER_BANK)))
    else $error("point number beyond bank count");

endmodule : bbce_checker

bind bank_bit_change_events_unit bbce_checker u_bbce_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire

// ===== bench/point_event_checker.sv =====
// ----------------------------------------------------------------------------
// point_event_checker
// Watches both channels of the bank change detector. It keeps its own copy of
// the per-bank bytes, turns every accepted request into the point events it
// should cause, and compares each accepted event with the oldest one queued.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module point_event_checker
  import bbce_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_item_t    in_item_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_item_t   out_item_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  logic [BITS_PER_BANK-1:0] bank_copy [NUM_BANKS];
  out_item_t                pending_events [$];
  int unsigned              fail_count = 0;

  // One event per flipped bit, bit 0 first; last marks the highest flip.
  function automatic void predict_changes(input in_item_t req);
    logic [BITS_PER_BANK-1:0] flips;
    out_item_t                ev;
    int                       point;
    if (req.bank >= NUM_BANKS) return;
    flips = bank_copy[req.bank] ^ req.data;
    bank_copy[req.bank] = req.data;
    for (int b = 0; b < BITS_PER_BANK; b++) begin
      if (flips[b]) begin
        point = int'(req.bank) * BITS_PER_BANK + b + 1;
        ev.point_id    = POINT_W'(point);
        ev.point_state = req.data[b];
        ev.last        = ((flips >> (b + 1)) == '0);
        pending_events.push_back(ev);
      end
    end
  endfunction

  function automatic void check_event(input out_item_t got);
    out_item_t want;
    if (pending_events.size() == 0) begin
      $display("%0t: unexpected event: expected none, actual id=%0d state=%0b last=%0b",
               $time, got.point_id, got.point_state, got.last);
      fail_count++;
      return;
    end
    want = pending_events.pop_front();
    if (got.point_id !== want.point_id) begin
      $display("%0t: point_id mismatch: expected %0d, actual %0d",
               $time, want.point_id, got.point_id);
      fail_count++;
    end
    if (got.point_state !== want.point_state) begin
      $display("%0t: point_state mismatch (id %0d): expected %0b, actual %0b",
               $time, want.point_id, want.point_state, got.point_state);
      fail_count++;
    end
    if (got.last !== want.last) begin
      $display("%0t: last mismatch (id %0d): expected %0b, actual %0b",
               $time, want.point_id, want.last, got.last);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (bank_copy[i]) bank_copy[i] = '0;
      pending_events.delete();
    end else begin
      if (in_valid_i && in_ready_i) predict_changes(in_item_i);
      if (out_valid_i && out_ready_i) check_event(out_item_i);
    end
    fail_count_o = fail_count;
    pending_o    = pending_events.size();
  end

endmodule : point_event_checker

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives bank/byte requests into the change detector: a directed set for the
// edge cases, then random traffic with bursty requests and a stalling sink.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import bbce_pkg::*;

  localparam int RANDOM_REQUESTS = 410;
  localparam int IDLE_LIMIT      = 2000;
  localparam int DRAIN_CYCLES    = 24;

  typedef enum {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_SPARSE,
    RDY_TOGGLE
  } ready_mode_e;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_item_t    in_item_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_item_o;
  int unsigned fail_count;
  int unsigned pending;

  int          burst_left  = 0;
  int          mode_left   = 0;
  int          idle_cycles = 0;
  ready_mode_e ready_mode  = RDY_ALWAYS;
  in_item_t    last_req    = '0;

  bank_bit_change_events_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  point_event_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_item_i    (in_item_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_i   (out_item_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Sink readiness follows a random mode that is redrawn when its countdown runs out
  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      ready_mode = ready_mode_e'($urandom_range(0, 3));
      mode_left  = $urandom_range(20, 80);
    end
    mode_left--;
    case (ready_mode)
      RDY_ALWAYS: out_ready_i <= 1'b1;
      RDY_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
      RDY_SPARSE: out_ready_i <= ($urandom_range(0, 5) == 0);
      default:    out_ready_i <= ~out_ready_i;
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Requests go out in bursts; a gap of idle cycles may precede each burst.
  task automatic send_request(input logic [7:0] bank, input logic [7:0] data);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 10);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_item_i.bank <= bank;
    in_item_i.data <= data;
    in_valid_i     <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    last_req.bank = bank;
    last_req.data = data;
  endtask

  initial begin
    int          kind;
    int unsigned sent;
    logic [7:0]  bank;
    logic [7:0]  data;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part
    send_request(8'd0, 8'h00);                   // unchanged after reset
    send_request(8'd0, 8'hFF);                   // all eight bits rise
    send_request(8'd0, 8'h00);                   // all eight bits fall
    send_request(8'(NUM_BANKS - 1), 8'h80);      // highest point only
    send_request(8'(NUM_BANKS - 1), 8'h80);      // unchanged
    send_request(8'(NUM_BANKS - 1), 8'h01);      // lowest and highest bit
    send_request(8'(NUM_BANKS), 8'hFF);          // first bank out of range
    send_request(8'd255, 8'hAA);                 // top bank value, ignored
    send_request(8'd32, 8'h0F);                  // out of range, aliases bank 0
    send_request(8'd128, 8'hF0);                 // out of range, aliases bank 0
    send_request(8'd0, 8'h0F);                   // bank 0 must still read as zero
    send_request(8'd1, 8'h55);
    send_request(8'd1, 8'hAA);
    send_request(8'd5, 8'h01);
    send_request(8'd5, 8'h03);
    send_request(8'd5, 8'h02);
    send_request(8'd12, 8'h10);
    send_request(8'd12, 8'h10);
    send_request(8'(NUM_BANKS - 1), 8'hFF);
    send_request(8'(NUM_BANKS - 1), 8'h00);

    // Random part
    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      kind = $urandom_range(0, 99);
      bank = 8'($urandom_range(0, NUM_BANKS - 1));
      data = 8'($urandom_range(0, 255));
      if (kind < 12) begin
        bank = 8'($urandom_range(NUM_BANKS, 255));
      end else if (kind < 22) begin
        bank = last_req.bank;
        data = last_req.data;
      end else if (kind < 40) begin
        bank = last_req.bank;
        data = last_req.data ^ (8'h01 << $urandom_range(0, 7));
      end else if (kind < 48) begin
        data = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
      end
      send_request(bank, data);
      sent++;
    end
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule : tb_top
